[rtl/core/fpasmd_pkg.sv]
// Shared types and constants for the binary32 add/sub/mul/div pipeline.
package fpasmd_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  localparam logic signed [11:0] BIAS    = 12'sd127;
  localparam logic signed [11:0] EXP_MAX = 12'sd255;

  localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
  localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
  localparam logic [31:0] INF_BITS   = 32'h7F80_0000;

  // Divider retires two quotient bits per stage, 26 bits in all
  localparam int DIV_STAGES = 13;
  localparam int NUM_STAGES = DIV_STAGES + 5;

  // Per-word pipeline payload
  typedef struct packed {
    op_e                op;
    logic               spec;   // result fixed by special-value rules
    logic [31:0]        res;    // special value, then final result
    logic               sa;
    logic               sb;
    logic               za;
    logic               zb;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic signed [9:0]  ea;
    logic signed [9:0]  eb;
    logic [5:0]         dsh;    // alignment shift, 32 means all gone
    logic               s;
    logic [47:0]        m;
    logic signed [11:0] e;
    logic [25:0]        rem;
    logic [25:0]        quo;
    logic [5:0]         p;      // leading one position of m
    logic signed [11:0] be;     // biased result exponent
  } st_t;

endpackage

[rtl/core/fpasmd_unpack.sv]
// Operand decode, subnormal normalization and special-value resolution.
module fpasmd_unpack (
  input  fpasmd_pkg::op_e op_i,
  input  logic [31:0]     a_i,
  input  logic [31:0]     b_i,
  output fpasmd_pkg::st_t st_o
);
  import fpasmd_pkg::*;

  typedef struct packed {
    logic              s;
    logic [23:0]       m;
    logic signed [9:0] e;
    logic              z;
    logic              inf;
    logic              nan;
  } opnd_t;

  function automatic opnd_t unpack_op(logic [31:0] x);
    opnd_t      o;
    logic [4:0] p;
    logic [4:0] sh;
    o.s   = x[31];
    o.z   = (x[30:0] == 31'd0);
    o.inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    o.nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    p     = 5'd0;
    sh    = 5'd0;
    if (x[30:23] == 8'd0) begin
      for (int i = 0; i < 23; i++) begin
        if (x[i]) p = 5'(i);
      end
      sh  = 5'd23 - p;
      o.m = {1'b0, x[22:0]} << sh;
      o.e = -10'sd149 - $signed({5'b0, sh});
    end else begin
      o.m = {1'b1, x[22:0]};
      o.e = $signed({2'b0, x[30:23]}) - 10'sd150;
    end
    return o;
  endfunction

  opnd_t ua, ub;
  logic  sb_eff, s_md;

  // Decode both operands and pick any fixed result
  always_comb begin
    ua     = unpack_op(a_i);
    ub     = unpack_op(b_i);
    sb_eff = ub.s ^ (op_i == OP_SUB);
    s_md   = ua.s ^ ub.s;
    st_o      = '0;
    st_o.op   = op_i;
    st_o.sa   = ua.s;
    st_o.sb   = sb_eff;
    st_o.za   = ua.z;
    st_o.zb   = ub.z;
    st_o.ma   = ua.m;
    st_o.mb   = ub.m;
    st_o.ea   = ua.e;
    st_o.eb   = ub.e;
    if (ua.nan) begin
      st_o.spec = 1'b1;
      st_o.res  = a_i | QUIET_BIT;
    end else if (ub.nan) begin
      st_o.spec = 1'b1;
      st_o.res  = b_i | QUIET_BIT;
    end else begin
      case (op_i)
        OP_ADD, OP_SUB: begin
          if (ua.inf) begin
            st_o.spec = 1'b1;
            st_o.res  = (ub.inf && (ua.s != sb_eff)) ? QNAN_BITS : a_i;
          end else if (ub.inf) begin
            st_o.spec = 1'b1;
            st_o.res  = {sb_eff, b_i[30:0]};
          end
        end
        OP_MUL: begin
          if (ua.inf || ub.inf) begin
            st_o.spec = 1'b1;
            st_o.res  = (ua.z || ub.z) ? QNAN_BITS : {s_md, INF_BITS[30:0]};
          end else if (ua.z || ub.z) begin
            st_o.spec = 1'b1;
            st_o.res  = {s_md, 31'd0};
          end
        end
        OP_DIV: begin
          st_o.spec = 1'b1;
          if (ua.inf) begin
            st_o.res = ub.inf ? QNAN_BITS : {s_md, INF_BITS[30:0]};
          end else if (ub.inf) begin
            st_o.res = {s_md, 31'd0};
          end else if (ub.z) begin
            st_o.res = ua.z ? QNAN_BITS : {s_md, INF_BITS[30:0]};
          end else if (ua.z) begin
            st_o.res = {s_md, 31'd0};
          end else begin
            st_o.spec = 1'b0;
          end
        end
        default: st_o.spec = 1'b0;
      endcase
    end
  end

endmodule

[rtl/core/fpasmd_addmul.sv]
// Adder swap/align/sum, multiplier array and divider setup.
module fpasmd_addmul (
  input  fpasmd_pkg::st_t prep_i,
  output fpasmd_pkg::st_t prep_o,
  input  fpasmd_pkg::st_t sum_i,
  output fpasmd_pkg::st_t sum_o
);
  import fpasmd_pkg::*;

  logic               is_add, swap;
  logic signed [10:0] d;
  logic [47:0]        prod;

  // Order adder operands, multiply, seed divider
  always_comb begin
    prep_o = prep_i;
    is_add = (prep_i.op == OP_ADD) || (prep_i.op == OP_SUB);
    swap   = is_add && !prep_i.zb &&
             (prep_i.za || (prep_i.eb > prep_i.ea) ||
              ((prep_i.eb == prep_i.ea) && (prep_i.mb > prep_i.ma)));
    if (swap) begin
      prep_o.ma = prep_i.mb;
      prep_o.mb = prep_i.ma;
      prep_o.ea = prep_i.eb;
      prep_o.eb = prep_i.ea;
      prep_o.sa = prep_i.sb;
      prep_o.sb = prep_i.sa;
      prep_o.za = prep_i.zb;
      prep_o.zb = prep_i.za;
    end
    d = 11'(prep_o.ea) - 11'(prep_o.eb);
    prep_o.dsh = (prep_o.zb || (d >= 11'sd32)) ? 6'd32 : 6'(d);
    prod = 48'(prep_i.ma) * 48'(prep_i.mb);
    prep_o.rem = {2'b0, prep_i.ma};
    prep_o.quo = '0;
    case (prep_i.op)
      OP_MUL: begin
        prep_o.m = prod;
        prep_o.e = 12'(prep_i.ea) + 12'(prep_i.eb);
        prep_o.s = prep_i.sa ^ prep_i.sb;
      end
      OP_DIV: begin
        prep_o.e = 12'(prep_i.ea) - 12'(prep_i.eb) - 12'sd25;
        prep_o.s = prep_i.sa ^ prep_i.sb;
      end
      default: begin
        prep_o.e = 12'(prep_o.ea) - 12'sd3;
      end
    endcase
  end

  logic [26:0] x, y, ys, lost;
  logic        sticky;
  logic [27:0] r;

  // Align the smaller operand and add or subtract
  always_comb begin
    sum_o  = sum_i;
    x      = {sum_i.ma, 3'b000};
    y      = {sum_i.mb, 3'b000};
    ys     = sum_i.dsh[5] ? 27'd0 : (y >> sum_i.dsh[4:0]);
    lost   = y & ~({27{1'b1}} << sum_i.dsh[4:0]);
    sticky = sum_i.dsh[5] ? (|y) : (|lost);
    if (sum_i.sa == sum_i.sb) begin
      r = 28'(x) + 28'(ys);
    end else begin
      r = 28'(x) - 28'(ys) - 28'(sticky);
    end
    if ((sum_i.op == OP_ADD) || (sum_i.op == OP_SUB)) begin
      sum_o.m = 48'(r);
      sum_o.s = ((sum_i.sa != sum_i.sb) && (r == 28'd0)) ? 1'b0 : sum_i.sa;
    end
  end

endmodule

[rtl/core/fpasmd_div_step.sv]
// One divider stage: two restoring quotient bits.
module fpasmd_div_step (
  input  fpasmd_pkg::st_t st_i,
  output fpasmd_pkg::st_t st_o
);
  import fpasmd_pkg::*;

  logic [25:0] r, q, dv;
  logic        ge;

  // Compare, subtract, shift twice
  always_comb begin
    st_o = st_i;
    r    = st_i.rem;
    q    = st_i.quo;
    dv   = {2'b0, st_i.mb};
    ge   = 1'b0;
    for (int i = 0; i < 2; i++) begin
      ge = (r >= dv);
      if (ge) r = r - dv;
      q = {q[24:0], ge};
      r = {r[24:0], 1'b0};
    end
    st_o.rem = r;
    st_o.quo = q;
  end

endmodule

[rtl/core/fpasmd_pack.sv]
// Leading-one search, exponent range check and result assembly.
module fpasmd_pack (
  input  fpasmd_pkg::st_t norm_i,
  output fpasmd_pkg::st_t norm_o,
  input  fpasmd_pkg::st_t fin_i,
  output fpasmd_pkg::st_t fin_o
);
  import fpasmd_pkg::*;

  logic [5:0] p;

  // Find the leading one and form the biased exponent
  always_comb begin
    norm_o = norm_i;
    if (norm_i.op == OP_DIV) norm_o.m = 48'(norm_i.quo);
    p = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (norm_o.m[i]) p = 6'(i);
    end
    norm_o.p  = p;
    norm_o.be = $signed(12'(p)) + norm_i.e + BIAS;
  end

  logic [47:0] sig;

  // Normalize the significand and assemble the word
  always_comb begin
    fin_o = fin_i;
    if (fin_i.p >= 6'd23) begin
      sig = fin_i.m >> (6'(fin_i.p - 6'd23));
    end else begin
      sig = fin_i.m << (6'(6'd23 - fin_i.p));
    end
    if (!fin_i.spec) begin
      if (fin_i.m == 48'd0) begin
        fin_o.res = {fin_i.s, 31'd0};
      end else if (fin_i.be >= EXP_MAX) begin
        fin_o.res = {fin_i.s, INF_BITS[30:0]};
      end else if (fin_i.be <= 12'sd0) begin
        fin_o.res = {fin_i.s, 31'd0};
      end else begin
        fin_o.res = {fin_i.s, fin_i.be[7:0], sig[22:0]};
      end
    end
  end

endmodule

[rtl/core/fp32_add_sub_mul_div.sv]
// Pipelined binary32 add, subtract, multiply and divide, truncating.
// Throughput: one word per cycle unless the output stalls; the 13-stage radix-4 divider sets the depth.
// Every stage holds its word under backpressure and refills when its
// successor moves, so bubbles are squeezed out while the output stalls.
// Reset (rst_ni low, asynchronous) clears all stage valid bits.
module fp32_add_sub_mul_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] operand_a, [63:32] operand_b
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] result_bits
);
  import fpasmd_pkg::*;

  localparam int NormIdx = 2 + DIV_STAGES;

  st_t                   st_q [NUM_STAGES];
  st_t                   st_d [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] adv;

  // Decode stage
  fpasmd_unpack u_unpack (
    .op_i (op_e'(s_axis_tuser_i)),
    .a_i  (s_axis_tdata_i[31:0]),
    .b_i  (s_axis_tdata_i[63:32]),
    .st_o (st_d[0])
  );

  // Swap/multiply stage and sum stage
  fpasmd_addmul u_addmul (
    .prep_i (st_q[0]),
    .prep_o (st_d[1]),
    .sum_i  (st_q[1]),
    .sum_o  (st_d[2])
  );

  // Divider stages
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    fpasmd_div_step u_div_step (
      .st_i (st_q[2 + k]),
      .st_o (st_d[3 + k])
    );
  end

  // Normalize and assemble stages
  fpasmd_pack u_pack (
    .norm_i (st_q[NormIdx]),
    .norm_o (st_d[NormIdx + 1]),
    .fin_i  (st_q[NormIdx + 1]),
    .fin_o  (st_d[NormIdx + 2])
  );

  // Advance a stage when it is empty or its successor moves
  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k + 1];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k - 1];
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (adv[k]) st_q[k] <= st_d[k];
    end
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = vld_q[NUM_STAGES-1];
  assign m_axis_tdata_o  = st_q[NUM_STAGES-1].res;

endmodule
